/* hdl/rat_pkg.sv */
// Shared types and constants for the range address translator.
package rat_pkg;

   // Number of range entries, one per cell of the chain.
   localparam int TABLE_ENTRIES = 16;
   localparam int ADDR_W = 64;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   // Request kinds.
   localparam logic KIND_LOAD      = 1'b0;
   localparam logic KIND_TRANSLATE = 1'b1;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_MISS    = 2'd1;
   localparam status_type STATUS_INVALID = 2'd2;
   localparam status_type STATUS_FULL    = 2'd3;

   // One stored range.
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] stop;
      logic [ADDR_W-1:0] target;
   } entry_type;

   // Lookup token that walks the chain, carrying the best candidate so far.
   typedef struct packed {
      logic              active;
      logic [ADDR_W-1:0] addr;
      logic              found;
      entry_type         best;
   } probe_type;

endpackage

/* hdl/rat_cell.sv */
// One range cell: holds an entry and refines the lookup token passing through.
module rat_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  rat_pkg::entry_type  wr_entry,
   input  rat_pkg::probe_type  probe_up,
   output rat_pkg::probe_type  probe_down
);

   rat_pkg::entry_type entry_ff;
   logic               valid_ff;
   rat_pkg::probe_type probe_ff;
   rat_pkg::probe_type probe_in;
   logic               take;

   // A later cell wins ties on equal base, as it was loaded later.
   always_comb begin
      take = valid_ff && (entry_ff.start <= probe_up.addr) &&
             (!probe_up.found || (entry_ff.start >= probe_up.best.start));
      probe_in = probe_up;
      if (take) begin
         probe_in.found = 1'b1;
         probe_in.best  = entry_ff;
      end
   end

   // Entry storage; only the valid bit is cleared by reset.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_entry;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= 1'b1;
      end
   end

   // Hand the token to the next cell; reset drops any token in flight.
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   assign probe_down = probe_ff;

endmodule

/* hdl/range_address_translator.sv */
// Top level of the range address translator: control sequencer and cell chain.
//
// Usage. Items arrive on the req_ channel (valid/stall); req_kind 0 loads one
// range (req_address, req_end_address, req_length, req_storage_base) into the
// next free cell, req_kind 1 translates req_address/req_length. Each item
// gives exactly one transfer on the rsp_ channel: rsp_status and
// rsp_storage_offset (zero unless a translation succeeded).
// The block works on one item at a time. A load passes through S_LOAD, which
// registers its result onto the rsp_ ports. A translation injects a token in
// S_SETUP into a chain of TABLE_ENTRIES cells, one cell per cycle, waits in
// S_WALK until it leaves the chain, then passes S_CHECK and S_SUM, which
// registers its result. A new item is taken as soon as the previous result has
// been transferred or is being transferred in the same cycle, so no item is
// taken before the previous one is finished.
// When the receiver holds rsp_stall, the result stays on the ports unchanged
// and req_stall stays high. Reset empties the table (all cells invalid, count
// zero) and clears any item in flight; no clearing pass is needed.
module range_address_translator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [rat_pkg::ADDR_W-1:0]          req_address,
   input  logic [rat_pkg::ADDR_W-1:0]          req_end_address,
   input  logic [rat_pkg::ADDR_W-1:0]          req_length,
   input  logic [rat_pkg::ADDR_W-1:0]          req_storage_base,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rat_pkg::status_type                 rsp_status,
   output logic [rat_pkg::ADDR_W-1:0]          rsp_storage_offset
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_SETUP,
      S_WALK,
      S_CHECK,
      S_SUM
   } state_type;

   state_type                        state_ff, state_in;
   logic [rat_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic [rat_pkg::ADDR_W-1:0]       stop_ff, stop_in;
   logic [rat_pkg::ADDR_W-1:0]       len_ff, len_in;
   logic [rat_pkg::ADDR_W-1:0]       target_ff, target_in;
   logic [rat_pkg::ADDR_W:0]         end_ff, end_in;
   logic                             miss_ff, miss_in;
   logic                             found_ff, found_in;
   rat_pkg::entry_type               pick_ff, pick_in;
   logic [rat_pkg::ADDR_W-1:0]       disp_ff, disp_in;
   logic [rat_pkg::CNT_W-1:0]        count_ff, count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   rat_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [rat_pkg::ADDR_W-1:0]       rsp_offset_ff, rsp_offset_in;

   logic                             accept;
   logic                             load_write;
   logic                             load_bad;
   logic                             load_full;
   logic [rat_pkg::ADDR_W:0]         target_sum;
   logic [rat_pkg::ADDR_W:0]         offset_sum;
   rat_pkg::entry_type               wr_entry;
   logic [rat_pkg::TABLE_ENTRIES-1:0] wr_en;
   rat_pkg::probe_type               chain [rat_pkg::TABLE_ENTRIES+1];

   // Take an item only when idle and the result slot is free or freeing.
   assign req_stall = !((state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;

   // Load checks: the range must be non-empty, sized consistently and fit in storage.
   always_comb begin
      target_sum = {1'b0, target_ff} + {1'b0, len_ff};
      load_bad   = (stop_ff <= addr_ff) || (len_ff != (stop_ff - addr_ff)) ||
                   target_sum[rat_pkg::ADDR_W];
      load_full  = (count_ff == rat_pkg::CNT_W'(rat_pkg::TABLE_ENTRIES));
      load_write = (state_ff == S_LOAD) && !load_bad && !load_full;
      wr_entry   = '{start: addr_ff, stop: stop_ff, target: target_ff};
      offset_sum = {1'b0, pick_ff.target} + {1'b0, disp_ff};
   end

   // Write enable for the cell at the current fill position.
   always_comb begin
      for (int i = 0; i < rat_pkg::TABLE_ENTRIES; i++) begin
         wr_en[i] = load_write && (count_ff == rat_pkg::CNT_W'(i));
      end
   end

   // Token injected at the head of the chain.
   always_comb begin
      chain[0]        = '0;
      chain[0].active = (state_ff == S_SETUP);
      chain[0].addr   = addr_ff;
   end

   // Chain of range cells.
   for (genvar g = 0; g < rat_pkg::TABLE_ENTRIES; g++) begin : g_cell
      rat_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (wr_en[g]),
         .wr_entry   (wr_entry),
         .probe_up   (chain[g]),
         .probe_down (chain[g+1])
      );
   end

   // Sequencer next-state and result logic.
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      stop_in       = stop_ff;
      len_in        = len_ff;
      target_in     = target_ff;
      end_in        = end_ff;
      miss_in       = miss_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      disp_in       = disp_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               addr_in   = req_address;
               stop_in   = req_end_address;
               len_in    = req_length;
               target_in = req_storage_base;
               state_in  = (req_kind == rat_pkg::KIND_TRANSLATE) ? S_SETUP : S_LOAD;
            end
         end
         S_LOAD: begin
            rsp_valid_in  = 1'b1;
            rsp_offset_in = '0;
            if (load_bad) begin
               rsp_status_in = rat_pkg::STATUS_INVALID;
            end else if (load_full) begin
               rsp_status_in = rat_pkg::STATUS_FULL;
            end else begin
               rsp_status_in = rat_pkg::STATUS_OK;
               count_in      = count_ff + rat_pkg::CNT_W'(1);
            end
            state_in = S_IDLE;
         end
         S_SETUP: begin
            end_in   = {1'b0, addr_ff} + {1'b0, len_ff};
            miss_in  = (len_ff == '0) || end_in[rat_pkg::ADDR_W];
            state_in = S_WALK;
         end
         S_WALK: begin
            if (chain[rat_pkg::TABLE_ENTRIES].active) begin
               found_in = chain[rat_pkg::TABLE_ENTRIES].found;
               pick_in  = chain[rat_pkg::TABLE_ENTRIES].best;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            miss_in  = miss_ff || !found_ff ||
                       (end_ff[rat_pkg::ADDR_W-1:0] > pick_ff.stop);
            disp_in  = addr_ff - pick_ff.start;
            state_in = S_SUM;
         end
         S_SUM: begin
            rsp_valid_in = 1'b1;
            if (miss_ff || offset_sum[rat_pkg::ADDR_W]) begin
               rsp_status_in = rat_pkg::STATUS_MISS;
               rsp_offset_in = '0;
            end else begin
               rsp_status_in = rat_pkg::STATUS_OK;
               rsp_offset_in = offset_sum[rat_pkg::ADDR_W-1:0];
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      stop_ff       <= stop_in;
      len_ff        <= len_in;
      target_ff     <= target_in;
      end_ff        <= end_in;
      miss_ff       <= miss_in;
      found_ff      <= found_in;
      pick_ff       <= pick_in;
      disp_ff       <= disp_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_storage_offset = rsp_offset_ff;

endmodule

/* tb/sv/translation_checker.sv */
// Result checker for the range address translator testbench.
`timescale 1ns / 1ps

module translation_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_kind,
   input  logic [rat_pkg::ADDR_W-1:0]          req_address,
   input  logic [rat_pkg::ADDR_W-1:0]          req_end_address,
   input  logic [rat_pkg::ADDR_W-1:0]          req_length,
   input  logic [rat_pkg::ADDR_W-1:0]          req_storage_base,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  rat_pkg::status_type                 rsp_status,
   input  logic [rat_pkg::ADDR_W-1:0]          rsp_storage_offset,
   output int                                  failures,
   output int                                  pending
);

   typedef logic [rat_pkg::ADDR_W-1:0] word_type;

   typedef struct packed {
      rat_pkg::status_type status;
      word_type            offset;
   } outcome_type;

   // Shadow copy of the range table.
   word_type    seg_lo     [rat_pkg::TABLE_ENTRIES];
   word_type    seg_hi     [rat_pkg::TABLE_ENTRIES];
   word_type    seg_target [rat_pkg::TABLE_ENTRIES];
   bit          seg_used   [rat_pkg::TABLE_ENTRIES];
   int          seg_fill;

   // Outcomes still owed by the block, oldest first.
   outcome_type due_results[$];

   initial begin
      failures = 0;
      pending  = 0;
   end

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      failures++;
   endtask

   // A load is checked for shape first, then for room in the table.
   function automatic rat_pkg::status_type predict_load(input word_type lo, input word_type hi,
                                                        input word_type size,
                                                        input word_type tgt);
      if (hi <= lo || size != hi - lo || tgt > ~size)
         return rat_pkg::STATUS_INVALID;
      if (seg_fill == rat_pkg::TABLE_ENTRIES)
         return rat_pkg::STATUS_FULL;
      seg_lo[seg_fill]     = lo;
      seg_hi[seg_fill]     = hi;
      seg_target[seg_fill] = tgt;
      seg_used[seg_fill]   = 1'b1;
      seg_fill++;
      return rat_pkg::STATUS_OK;
   endfunction

   // The entry with the greatest base at or below the address wins; on equal
   // bases the later entry wins. Only that entry is tried.
   function automatic outcome_type predict_lookup(input word_type addr, input word_type len);
      outcome_type res;
      bit          found;
      int          pick;
      word_type    disp;
      res.status = rat_pkg::STATUS_MISS;
      res.offset = '0;
      found      = 1'b0;
      pick       = 0;
      if (seg_fill == 0 || len == 0 || addr > ~len)
         return res;
      for (int i = 0; i < rat_pkg::TABLE_ENTRIES; i++) begin
         if (seg_used[i] && seg_lo[i] <= addr && (!found || seg_lo[i] >= seg_lo[pick])) begin
            pick  = i;
            found = 1'b1;
         end
      end
      if (!found || addr + len > seg_hi[pick])
         return res;
      disp = addr - seg_lo[pick];
      if (seg_target[pick] > ~disp)
         return res;
      res.status = rat_pkg::STATUS_OK;
      res.offset = seg_target[pick] + disp;
      return res;
   endfunction

   // Results are matched before new requests are queued, so a result can
   // never be paired with a request accepted at the same edge.
   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < rat_pkg::TABLE_ENTRIES; i++)
            seg_used[i] = 1'b0;
         seg_fill = 0;
         due_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.status = rsp_status;
            got.offset = rsp_storage_offset;
            if (due_results.size() == 0) begin
               report($sformatf("unexpected transfer, status %0d offset %h",
                                got.status, got.offset));
            end else begin
               want = due_results.pop_front();
               if (got.status !== want.status)
                  report($sformatf("status %0d, wanted %0d", got.status, want.status));
               if (got.offset !== want.offset)
                  report($sformatf("storage offset %h, wanted %h", got.offset, want.offset));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_kind == rat_pkg::KIND_TRANSLATE) begin
               want = predict_lookup(req_address, req_length);
            end else begin
               want.status = predict_load(req_address, req_end_address, req_length,
                                          req_storage_base);
               want.offset = '0;
            end
            due_results.insert(due_results.size(), want);
         end
      end
      pending <= due_results.size();
   end

endmodule

/* tb/sv/range_address_translator_test.sv */
// Stimulus, handshake pacing and verdict for the range address translator.
`timescale 1ns / 1ps

module range_address_translator_test;

   typedef logic [rat_pkg::ADDR_W-1:0] word_type;

   localparam int       RANDOM_ITEMS = 2000;
   localparam int       PHASE_ITEMS  = 250;
   localparam int       IDLE_LIMIT   = 5000;
   localparam word_type ADDR_MAX     = '1;

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic                req_kind         = rat_pkg::KIND_LOAD;
   word_type            req_address      = '0;
   word_type            req_end_address  = '0;
   word_type            req_length       = '0;
   word_type            req_storage_base = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   rat_pkg::status_type rsp_status;
   word_type            rsp_storage_offset;
   int                  failures;
   int                  pending;

   bit                  steady_sender   = 1'b0;
   bit                  steady_receiver = 1'b0;
   int                  stall_left      = 0;
   int                  idle_cycles     = 0;

   // Ranges offered as well-formed loads, used to aim translations.
   word_type            known_lo[$];
   word_type            known_hi[$];

   range_address_translator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_address        (req_address),
      .req_end_address    (req_end_address),
      .req_length         (req_length),
      .req_storage_base   (req_storage_base),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_storage_offset (rsp_storage_offset)
   );

   translation_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_address        (req_address),
      .req_end_address    (req_end_address),
      .req_length         (req_length),
      .req_storage_base   (req_storage_base),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_storage_offset (rsp_storage_offset),
      .failures           (failures),
      .pending            (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver back-pressure: runs of stall or no stall, mostly short.
   always @(posedge clock) begin
      if (steady_receiver) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         rsp_stall  <= ($urandom_range(0, 99) < 35);
         stall_left = ($urandom_range(0, 99) < 8) ? $urandom_range(10, 50)
                                                   : $urandom_range(0, 3);
      end
   end

   // Watchdog: ends the run if no transfer happens on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic word_type rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_sender || roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offers one request and holds it until the transfer, then sometimes idles a while.
   task automatic issue(input logic kind, input word_type addr, input word_type stop,
                        input word_type len, input word_type base);
      int gap;
      req_kind         <= kind;
      req_address      <= addr;
      req_end_address  <= stop;
      req_length       <= len;
      req_storage_base <= base;
      req_valid        <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds the sender back until every outstanding result has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending != 0);
   endtask

   // Mostly well-formed ranges, clustered on earlier bases and near the top
   // of the address space; a minority are malformed.
   task automatic random_load();
      word_type lo;
      word_type hi;
      word_type size;
      word_type tgt;
      int       roll;
      bit       wellformed;
      roll = $urandom_range(0, 99);
      if (known_lo.size() > 0 && roll < 35)
         lo = known_lo[$urandom_range(0, known_lo.size() - 1)]
              + ($urandom_range(0, 1) ? 64'd0 : 64'($urandom_range(1, 4096)));
      else if (roll < 55)
         lo = ADDR_MAX - 64'($urandom_range(1, 65536));
      else if (roll < 70)
         lo = 64'($urandom_range(0, 65535));
      else
         lo = rand64();
      roll = $urandom_range(0, 99);
      if (roll < 70)
         size = 64'($urandom_range(1, 8192));
      else if (roll < 90)
         size = {32'd0, $urandom} + 64'd1;
      else
         size = rand64();
      if (size == 0)
         size = 1;
      if (lo == ADDR_MAX)
         lo = lo - 1;
      if (size > ADDR_MAX - lo)
         size = ADDR_MAX - lo;
      hi = lo + size;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         tgt = ~size;
      else if (roll < 25)
         tgt = 64'($urandom_range(0, 65535));
      else
         tgt = rand64() % (~size + 64'd1);
      if (tgt > ~size)
         tgt = ~size;
      // Broken shapes: end not above base, wrong size, or storage overflow.
      wellformed = 1'b0;
      roll = $urandom_range(0, 99);
      if (roll < 6)
         hi = lo - 64'($urandom_range(0, 3));
      else if (roll < 10)
         size = size + 64'd1;
      else if (roll < 14)
         tgt = $urandom_range(0, 1) ? ADDR_MAX : ~size + 64'd1;
      else
         wellformed = 1'b1;
      if (wellformed && known_lo.size() < 48) begin
         known_lo.insert(known_lo.size(), lo);
         known_hi.insert(known_hi.size(), hi);
      end
      issue(rat_pkg::KIND_LOAD, lo, hi, size, tgt);
   endtask

   // Mostly aimed at a known range: inside it, flush with its end, one byte
   // past it, just below it, zero length or the whole range.
   task automatic random_translate();
      word_type addr;
      word_type len;
      word_type lo;
      word_type span;
      word_type off;
      word_type rest;
      int       idx;
      int       roll;
      roll = $urandom_range(0, 99);
      if (known_lo.size() > 0 && roll < 80) begin
         idx  = $urandom_range(0, known_lo.size() - 1);
         lo   = known_lo[idx];
         span = known_hi[idx] - lo;
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            off  = rand64() % span;
            rest = span - off;
            addr = lo + off;
            len  = 64'd1 + ($urandom_range(0, 1) ? rand64() % rest : 64'($urandom) % rest);
         end else if (roll < 55) begin
            len  = 64'd1 + 64'($urandom_range(0, 63)) % span;
            addr = lo + span - len;
         end else if (roll < 65) begin
            len  = 64'd1 + 64'($urandom_range(0, 63)) % span;
            addr = lo + span - len + 64'd1;
         end else if (roll < 75) begin
            addr = lo - 64'd1 - 64'($urandom_range(0, 15));
            len  = 64'($urandom_range(1, 16));
         end else if (roll < 85) begin
            addr = lo + rand64() % span;
            len  = '0;
         end else begin
            addr = lo;
            len  = span;
         end
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            addr = ADDR_MAX - 64'($urandom_range(0, 255));
            len  = 64'($urandom_range(1, 512));
         end else if (roll < 55) begin
            addr = rand64();
            len  = rand64();
         end else begin
            addr = rand64();
            len  = 64'($urandom_range(1, 4096));
         end
      end
      issue(rat_pkg::KIND_TRANSLATE, addr, rand64(), len, rand64());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: translation on an empty table, each malformed load,
      // misses of every kind, equal bases, ranges at both ends of the space.
      issue(rat_pkg::KIND_TRANSLATE, 64'h1000, ADDR_MAX, 64'h10, ADDR_MAX);
      issue(rat_pkg::KIND_LOAD, 64'h1000, 64'h1000, 64'h0, 64'h0);
      issue(rat_pkg::KIND_LOAD, 64'h2000, 64'h1000, 64'h1000, 64'h0);
      issue(rat_pkg::KIND_LOAD, 64'h1000, 64'h2000, 64'h0fff, 64'h0);
      issue(rat_pkg::KIND_LOAD, 64'h1000, 64'h2000, 64'h1000, ADDR_MAX);
      issue(rat_pkg::KIND_LOAD, 64'h1000, 64'h2000, 64'h1000, 64'h10_0000);
      issue(rat_pkg::KIND_TRANSLATE, 64'h1800, 64'h0, 64'h0, 64'h0);
      issue(rat_pkg::KIND_TRANSLATE, 64'h1800, 64'h0, 64'h100, 64'h0);
      issue(rat_pkg::KIND_TRANSLATE, 64'h10, 64'h0, 64'h4, 64'h0);
      issue(rat_pkg::KIND_TRANSLATE, 64'h1f00, 64'h0, 64'h101, 64'h0);
      issue(rat_pkg::KIND_TRANSLATE, ADDR_MAX, 64'h0, 64'h2, 64'h0);
      issue(rat_pkg::KIND_LOAD, 64'h1000, 64'h1800, 64'h800, 64'h20_0000);
      issue(rat_pkg::KIND_TRANSLATE, 64'h1100, 64'h0, 64'h100, 64'h0);
      issue(rat_pkg::KIND_TRANSLATE, 64'h1900, 64'h0, 64'h1, 64'h0);
      issue(rat_pkg::KIND_LOAD, ADDR_MAX - 64'hff, ADDR_MAX, 64'hff, 64'h40_0000);
      issue(rat_pkg::KIND_TRANSLATE, ADDR_MAX - 64'h10, ADDR_MAX, 64'h10, ADDR_MAX);
      issue(rat_pkg::KIND_LOAD, 64'h0, 64'h10, 64'h10, ADDR_MAX - 64'h10);
      issue(rat_pkg::KIND_TRANSLATE, 64'hf, 64'h0, 64'h1, 64'h0);
      issue(rat_pkg::KIND_TRANSLATE, 64'h0, 64'h0, ADDR_MAX, 64'h0);
      issue(rat_pkg::KIND_LOAD, 64'h0, ADDR_MAX, ADDR_MAX, 64'h0);
      issue(rat_pkg::KIND_TRANSLATE, 64'h5, 64'h0, 64'h20, 64'h0);
      known_lo.insert(known_lo.size(), 64'h1000);
      known_hi.insert(known_hi.size(), 64'h2000);
      drain();

      // Random part in phases, some of them without any idling.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            steady_sender   <= ($urandom_range(0, 3) == 0);
            steady_receiver <= ($urandom_range(0, 3) == 0);
         end
         if (n == RANDOM_ITEMS / 2)
            drain();
         if ($urandom_range(0, 99) < 25)
            random_load();
         else
            random_translate();
      end

      drain();
      repeat (rat_pkg::TABLE_ENTRIES + 8) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
